>>> rtl/esc_throttle_supervisor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the throttle supervisor
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ESC_THROTTLE_SUPERVISOR_ASSERT_SVH
`define ESC_THROTTLE_SUPERVISOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/esc_thr_pkg.sv
// ----------------------------------------------------------------------------
// esc_thr_pkg
// Shared widths, constants, types and the throttle mapping function.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_thr_pkg;

  localparam int PULSE_W = 16;
  localparam int DUTY_W  = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam int DEFAULT_WINDOW_DEPTH = 8;

  localparam logic [CFG_W-1:0] START_LEVEL_RST    = 8'd30;
  localparam logic [CFG_W-1:0] TIMEOUT_RELOAD_RST = 8'd125;

  localparam logic [PULSE_W-1:0] AVG_LOW    = 16'd1100;
  localparam logic [PULSE_W-1:0] AVG_HIGH   = 16'd1900;
  localparam logic [PULSE_W-1:0] AVG_OFFSET = 16'd1000;
  localparam logic [DUTY_W-1:0]  TARGET_MIN = 8'd25;
  localparam logic [DUTY_W-1:0]  TARGET_MAX = 8'd230;
  localparam logic [DUTY_W:0]    STOP_MARGIN = 9'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LEVEL    = 1'b0,
    CFG_TIMEOUT_RELOAD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] start_level;
    logic [CFG_W-1:0] timeout_reload;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              running;
    logic              start_request;
    logic              stop_event;
    logic [DUTY_W-1:0] target_duty;
  } tick_res_t;

  // Maps an averaged pulse width onto a target duty.
  function automatic logic [DUTY_W-1:0] map_target(input logic [PULSE_W-1:0] avg);
    logic [PULSE_W-1:0] diff;
    diff = avg - AVG_OFFSET;
    if (avg < AVG_LOW) begin
      map_target = TARGET_MIN;
    end else if (avg > AVG_HIGH) begin
      map_target = TARGET_MAX;
    end else begin
      map_target = diff[DUTY_W+1:2];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/esc_thr_window.sv
// ----------------------------------------------------------------------------
// esc_thr_window
// Moving-average window: a shift line of pulse widths and a running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_thr_window
  import esc_thr_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               shift_i,
  input  wire logic [PULSE_W-1:0] pulse_i,
  output logic      [PULSE_W-1:0] avg_o
);

  localparam int DEPTH_LOG = $clog2(WINDOW_DEPTH);
  localparam int SUM_W     = PULSE_W + DEPTH_LOG;
  localparam int SHIFT     = SUM_W + DEPTH_LOG;
  localparam int RECIP_W   = SUM_W + 2;
  localparam int PROD_W    = SUM_W + RECIP_W;
  // Rounded-up reciprocal; exact floor division for every sum below 2**SUM_W.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  logic [PULSE_W-1:0] taps_q [WINDOW_DEPTH];
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [PROD_W-1:0]  prod;

  // The oldest sample leaves the sum as the new one enters it.
  assign sum_d = sum_q - SUM_W'(taps_q[WINDOW_DEPTH-1]) + SUM_W'(pulse_i);
  assign prod  = PROD_W'(sum_d) * PROD_W'(RECIP);
  assign avg_o = prod[SHIFT +: PULSE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        taps_q[i] <= '0;
      end
    end else if (shift_i) begin
      sum_q     <= sum_d;
      taps_q[0] <= pulse_i;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/esc_thr_control.sv
// ----------------------------------------------------------------------------
// esc_thr_control
// Motor state: timeout countdown, start request, duty ramp and target.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_thr_control
  import esc_thr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic               comm_i,
  input  wire logic [PULSE_W-1:0] avg_i,
  input  wire cfg_t               cfg_i,
  output tick_res_t               res_o
);

  logic              run_q, run_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic [CFG_W-1:0]  timeout_q, timeout_d;
  logic [DUTY_W-1:0] target_q, target_d;
  logic              start_req, stopped;

  always_comb begin
    run_d     = run_q;
    duty_d    = duty_q;
    timeout_d = timeout_q;
    start_req = 1'b0;
    stopped   = 1'b0;

    // Commutation reloads the timeout only while running.
    if (comm_i && run_q) begin
      timeout_d = cfg_i.timeout_reload;
    end

    if (timeout_d != '0) begin
      timeout_d = timeout_d - CFG_W'(1);
      if (timeout_d == '0) begin
        stopped = run_d;
        run_d   = 1'b0;
        duty_d  = '0;
      end
    end

    // The start sequence loads the start level into the duty ahead of the ramp step.
    if (!run_d && (target_q >= cfg_i.start_level)) begin
      start_req = 1'b1;
      duty_d    = cfg_i.start_level;
      run_d     = 1'b1;
      timeout_d = cfg_i.timeout_reload;
    end

    if (run_d) begin
      if (duty_d < target_q) begin
        duty_d = duty_d + DUTY_W'(1);
      end else if (duty_d > target_q) begin
        duty_d = duty_d - DUTY_W'(1);
      end
      // Widened by one bit, so a start level of five or less never trips this.
      if (({1'b0, duty_d} + STOP_MARGIN) < {1'b0, cfg_i.start_level}) begin
        run_d     = 1'b0;
        duty_d    = '0;
        timeout_d = '0;
        stopped   = 1'b1;
      end
    end

    target_d = map_target(avg_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      duty_q    <= '0;
      timeout_q <= '0;
      target_q  <= '0;
    end else if (step_i) begin
      run_q     <= run_d;
      duty_q    <= duty_d;
      timeout_q <= timeout_d;
      target_q  <= target_d;
    end
  end

  assign res_o.duty          = duty_d;
  assign res_o.running       = run_d;
  assign res_o.start_request = start_req;
  assign res_o.stop_event    = stopped;
  assign res_o.target_duty   = target_d;

endmodule

`default_nettype wire

>>> rtl/esc_throttle_supervisor.sv
// ----------------------------------------------------------------------------
// esc_throttle_supervisor
// Tick supervisor of a brushless motor controller: timeout, start, duty ramp
// and pulse-width averaging, one tick per input beat.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    pulse_width_i, commutation_seen_i
// out       source     out_valid_o / out_stall_i  duty_o, running_o, start_request_o,
//                                                 stop_event_o, target_duty_o,
//                                                 average_pulse_o
// cfg       sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One beat is accepted per cycle while in_stall_o is low; each beat passes through the
// input register, then the result register, before its result is presented.
// The running sum, the reciprocal multiply and the motor rules form one combinational path
// from the input register to the result register.
// Reset clears the window, the motor state and restores the register defaults.
// A stalled result register holds the input register, and only then is in_stall_o raised.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_throttle_supervisor
  import esc_thr_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [PULSE_W-1:0]   pulse_width_i,
  input  wire logic                 commutation_seen_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [DUTY_W-1:0]    duty_o,
  output logic                      running_o,
  output logic                      start_request_o,
  output logic                      stop_event_o,
  output logic      [DUTY_W-1:0]    target_duty_o,
  output logic      [PULSE_W-1:0]   average_pulse_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               s1_valid_q;
  logic [PULSE_W-1:0] pulse_q;
  logic               comm_q;
  logic               in_accept, s1_adv;
  logic [PULSE_W-1:0] avg;
  tick_res_t          res;
  tick_res_t          res_q;
  logic [PULSE_W-1:0] avg_q;
  logic               out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_level    <= START_LEVEL_RST;
      cfg_q.timeout_reload <= TIMEOUT_RELOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_LEVEL:    cfg_q.start_level    <= cfg_wdata_i;
        CFG_TIMEOUT_RELOAD: cfg_q.timeout_reload <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The tick is evaluated as the input register moves into the result register.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pulse_q <= pulse_width_i;
      comm_q  <= commutation_seen_i;
    end
    if (s1_adv) begin
      res_q <= res;
      avg_q <= avg;
    end
  end

  esc_thr_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .pulse_i (pulse_q),
    .avg_o   (avg)
  );

  esc_thr_control u_control (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .comm_i (comm_q),
    .avg_i  (avg),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o     = out_valid_q;
  assign duty_o          = res_q.duty;
  assign running_o       = res_q.running;
  assign start_request_o = res_q.start_request;
  assign stop_event_o    = res_q.stop_event;
  assign target_duty_o   = res_q.target_duty;
  assign average_pulse_o = avg_q;

`include "esc_throttle_supervisor_assert.svh"

  `ESC_ASSERT_SAME(a_stall_needs_full_out, in_stall_o, out_valid_o && out_stall_i, "input stalled without a stalled result")
  `ESC_ASSERT_SAME(a_stopped_zero_duty, out_valid_o && !running_o, duty_o == '0, "stopped motor shows a non-zero duty")
  `ESC_ASSERT_SAME(a_start_runs, out_valid_o && start_request_o, running_o, "start request without the motor running")
  `ESC_ASSERT_SAME(a_stop_halts, out_valid_o && stop_event_o && !start_request_o, !running_o, "stop event left the motor running")
  `ESC_ASSERT_SAME(a_target_range, out_valid_o, (target_duty_o >= TARGET_MIN) && (target_duty_o <= TARGET_MAX), "target duty out of range")
  `ESC_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid_o, "evaluated tick produced no result")

endmodule

`default_nettype wire

>>> test/esc_throttle_supervisor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the throttle supervisor
// Drives ticks of pulse width and commutation through the valid/stall input
// channel, predicts every result beat from a behavioural copy of the motor
// rules and the moving average, and checks each output beat field by field.
// Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module esc_throttle_supervisor_test;
  import esc_thr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int AVG_DEPTH = DEFAULT_WINDOW_DEPTH;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               running;
    logic               start_request;
    logic               stop_event;
    logic [DUTY_W-1:0]  target_duty;
    logic [PULSE_W-1:0] average_pulse;
  } tick_expect_t;

  // Behavioural copy of the supervisor state with a queue of expected beats.
  class tick_scoreboard;
    logic [PULSE_W-1:0] window[AVG_DEPTH];
    int unsigned        wr_ptr;
    bit                 motor_on;
    logic [DUTY_W-1:0]  duty;
    logic [DUTY_W-1:0]  target;
    logic [CFG_W-1:0]   ticks_left;
    logic [CFG_W-1:0]   start_level;
    logic [CFG_W-1:0]   reload;
    tick_expect_t       expected_q[$];
    int                 errors;

    function new();
      foreach (window[i]) window[i] = '0;
      wr_ptr = 0;
      motor_on = 0;
      duty = '0;
      target = '0;
      ticks_left = '0;
      start_level = START_LEVEL_RST;
      reload = TIMEOUT_RELOAD_RST;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      if (idx == CFG_START_LEVEL) begin
        start_level = value;
      end else begin
        reload = value;
      end
    endfunction

    function void shut_down();
      motor_on = 0;
      duty = '0;
      ticks_left = '0;
    endfunction

    function void note_tick(logic [PULSE_W-1:0] pulse, logic comm);
      tick_expect_t e;
      int unsigned sum;
      logic [PULSE_W-1:0] avg;
      e = '0;
      if (comm && motor_on) ticks_left = reload;
      if (ticks_left != 0) begin
        ticks_left--;
        if (ticks_left == 0) begin
          if (motor_on) e.stop_event = 1'b1;
          shut_down();
        end
      end
      if (!motor_on && target >= start_level) begin
        e.start_request = 1'b1;
        duty = start_level;
        motor_on = 1;
        ticks_left = reload;
      end
      if (motor_on) begin
        if (duty < target) begin
          duty++;
        end else if (duty > target) begin
          duty--;
        end
        // The low-duty threshold is signed, so tiny start levels never trip it.
        if (int'(duty) + 5 < int'(start_level)) begin
          shut_down();
          e.stop_event = 1'b1;
        end
      end
      window[wr_ptr] = pulse;
      wr_ptr = (wr_ptr + 1 >= AVG_DEPTH) ? 0 : wr_ptr + 1;
      sum = 0;
      foreach (window[i]) sum += window[i];
      avg = PULSE_W'(sum / AVG_DEPTH);
      if (avg < AVG_LOW) begin
        target = TARGET_MIN;
      end else if (avg > AVG_HIGH) begin
        target = TARGET_MAX;
      end else begin
        target = DUTY_W'((avg - AVG_OFFSET) >> 2);
      end
      e.duty = duty;
      e.running = motor_on;
      e.target_duty = target;
      e.average_pulse = avg;
      expected_q.push_back(e);
    endfunction

    function void check_result(tick_expect_t got);
      tick_expect_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.duty !== e.duty) begin
        $display("%0t: duty expected %0d actual %0d", $time, e.duty, got.duty);
        errors++;
      end
      if (got.running !== e.running) begin
        $display("%0t: running expected %0b actual %0b", $time, e.running, got.running);
        errors++;
      end
      if (got.start_request !== e.start_request) begin
        $display("%0t: start_request expected %0b actual %0b", $time,
                 e.start_request, got.start_request);
        errors++;
      end
      if (got.stop_event !== e.stop_event) begin
        $display("%0t: stop_event expected %0b actual %0b", $time,
                 e.stop_event, got.stop_event);
        errors++;
      end
      if (got.target_duty !== e.target_duty) begin
        $display("%0t: target_duty expected %0d actual %0d", $time,
                 e.target_duty, got.target_duty);
        errors++;
      end
      if (got.average_pulse !== e.average_pulse) begin
        $display("%0t: average_pulse expected %0d actual %0d", $time,
                 e.average_pulse, got.average_pulse);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  logic [PULSE_W-1:0]   pulse_width = '0;
  logic                 commutation_seen = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  logic [DUTY_W-1:0]    duty_o;
  logic                 running_o;
  logic                 start_request_o;
  logic                 stop_event_o;
  logic [DUTY_W-1:0]    target_duty_o;
  logic [PULSE_W-1:0]   average_pulse_o;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_START_LEVEL;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bit no_idle = 0;
  bit hold_off_req = 0;

  tick_scoreboard sb = new();

  esc_throttle_supervisor u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .pulse_width_i     (pulse_width),
    .commutation_seen_i(commutation_seen),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .duty_o            (duty_o),
    .running_o         (running_o),
    .start_request_o   (start_request_o),
    .stop_event_o      (stop_event_o),
    .target_duty_o     (target_duty_o),
    .average_pulse_o   (average_pulse_o),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata)
  );

  initial begin
    forever begin
      #10 clk_i = ~clk_i;
    end
  end

  // Both channels are observed at the edge on which a beat is taken.
  always @(posedge clk_i) begin
    tick_expect_t got;
    if (rst_n && in_valid && !in_stall_o) sb.note_tick(pulse_width, commutation_seen);
    if (rst_n && out_valid_o && !out_stall) begin
      got.duty = duty_o;
      got.running = running_o;
      got.start_request = start_request_o;
      got.stop_event = stop_event_o;
      got.target_duty = target_duty_o;
      got.average_pulse = average_pulse_o;
      sb.check_result(got);
    end
  end

  // Receiver: random stalls, or one long hold-off so that the block backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 18);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("esc_throttle_supervisor verification failed");
    $finish;
  end

  task automatic send_tick(logic [PULSE_W-1:0] p, logic c);
    if (!no_idle) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    pulse_width <= p;
    commutation_seen <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Segments of steady throttle, sweeps, commutation drop-outs and noise.
  task automatic run_throttle(int n);
    int sent;
    int kind;
    int seg_len;
    int base;
    int slope;
    int val;
    logic c;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      seg_len = $urandom_range(4, 40);
      base = $urandom_range(900, 2100);
      slope = int'($urandom_range(40)) - 20;
      if (kind >= 70 && kind < 85 && $urandom_range(3) == 0) begin
        seg_len = $urandom_range(2, int'(sb.reload) + 8);
      end
      for (int k = 0; k < seg_len && sent < n; k++) begin
        c = ($urandom_range(9) != 0);
        if (kind < 45) begin
          val = base + int'($urandom_range(16)) - 8;
        end else if (kind < 70) begin
          val = base + k * slope;
        end else if (kind < 85) begin
          val = base;
          c = 1'b0;
        end else begin
          val = $urandom;
          c = 1'($urandom_range(1));
        end
        send_tick(val[PULSE_W-1:0], c);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // The first edge lets the monitor note a beat taken at the current edge.
  task automatic drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] level, logic [CFG_W-1:0] reload_val, int n,
                           bit calm, bit hold);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_START_LEVEL;
    cfg_wdata <= level;
    sb.write_reg(CFG_START_LEVEL, level);
    @(posedge clk_i);
    cfg_idx <= CFG_TIMEOUT_RELOAD;
    cfg_wdata <= reload_val;
    sb.write_reg(CFG_TIMEOUT_RELOAD, reload_val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    no_idle = calm;
    hold_off_req = hold;
    run_throttle(n);
  endtask

  initial begin
    logic [PULSE_W-1:0] directed[24];
    directed = '{16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1500,
                 16'd1500, 16'd1100, 16'd1099, 16'd1900, 16'd1901, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd2000,
                 16'd1101, 16'd1899};
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: start-up, saturation at both ends of the mapping.
    foreach (directed[i]) send_tick(directed[i], (i % 5) != 4);
    in_valid <= 1'b0;

    run_phase(8'd0, 8'd0, 150, 0, 0);      // starts at once, no timeout at all
    run_phase(8'd5, 8'd1, 150, 0, 0);      // reload of one stops on every tick
    run_phase(8'd6, 8'd255, 250, 1, 0);    // long stretch without idling
    run_phase(8'd255, 8'd20, 100, 0, 0);   // start level out of reach
    run_phase(8'd120, 8'd8, 250, 0, 1);    // receiver holds off for a while
    run_phase(8'($urandom_range(6, 255)), 8'($urandom_range(1, 40)), 300, 0, 0);
    run_phase(8'd30, 8'd125, 300, 0, 0);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("esc_throttle_supervisor verification clean");
    end else begin
      $display("esc_throttle_supervisor verification failed");
    end
    $finish;
  end

endmodule
